// File: hdl/yags_pkg.sv
`timescale 1ns / 1ps
package yags_pkg;

  localparam int CHOICE_ENTRIES = 4096;
  localparam int CACHE_SETS     = 1024;
  localparam int TAG_BITS       = 8;

  localparam int CHOICE_AW = $clog2(CHOICE_ENTRIES);
  localparam int SET_AW    = $clog2(CACHE_SETS);
  localparam int TAG_W     = TAG_BITS + 1;
  localparam int HIST_W    = SET_AW + 1;
  localparam int CLR_AW    = (CHOICE_AW > SET_AW) ? CHOICE_AW : SET_AW;
  localparam int CLR_DEPTH = 2 ** CLR_AW;
  localparam int SET_W     = 2 * TAG_W + 5;

  localparam logic [1:0] CTR_MAX = 2'h3;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_UPDATE = 1'b1
  } yags_cmd_e;

  typedef struct packed {
    yags_cmd_e   command;
    logic [31:0] branch_address;
    logic        taken_outcome;
  } yags_req_t;

  typedef struct packed {
    logic predict_taken;
    logic cache_hit;
  } yags_rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag0;
    logic [TAG_W-1:0] tag1;
    logic [1:0]       ctr0;
    logic [1:0]       ctr1;
    logic             lru;
  } yags_set_t;

endpackage

// File: hdl/yags_branch_predictor_core.sv
`timescale 1ns / 1ps
// After reset the block sweeps its tables to zero, over the depth of the deeper
// of the choice table and the two direction caches, with busy high. Then an
// item is taken when start is high and busy is low; its result is shown with
// rsp_valid_o for one cycle, after the calc state and the result register,
// and must be taken then since the receiver cannot stall. A new item may be
// accepted in the cycle the result is shown, but not before, as busy is high
// in the calc state. The choice table and both caches are read at acceptance;
// the calc state computes and writes the entries back through their single write ports.
module yags_branch_predictor_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  yags_pkg::yags_req_t  req_i,
  output logic                 rsp_valid_o,
  output yags_pkg::yags_rsp_t  rsp_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC
  } state_e;

  state_e                             state_q;
  logic [yags_pkg::CLR_AW-1:0]        clr_q;
  logic [yags_pkg::HIST_W-1:0]        hist_q;
  logic                               rsp_valid_q;
  yags_pkg::yags_rsp_t                rsp_q;
  yags_pkg::yags_req_t                item_q;

  logic                               accept;
  logic [29:0]                        acc_word;
  logic [29:0]                        word;
  logic [yags_pkg::CHOICE_AW-1:0]     chi;
  logic [yags_pkg::SET_AW-1:0]        acc_cai;
  logic [yags_pkg::SET_AW-1:0]        cai;
  logic [yags_pkg::TAG_W-1:0]         tag;
  logic [1:0]                         choice_rd;
  yags_pkg::yags_set_t                tk_rd;
  yags_pkg::yags_set_t                nt_rd;
  yags_pkg::yags_set_t                probed;
  yags_pkg::yags_set_t                set_wr;
  logic                               bias;
  logic                               outcome;
  logic                               way0;
  logic                               hit;
  logic [1:0]                         cca;
  logic                               pred;
  logic                               choice_upd;
  logic                               cache_wr;
  logic                               clearing;
  logic                               clr_choice;
  logic                               clr_set;

  logic                               ch_we;
  logic [yags_pkg::CHOICE_AW-1:0]     ch_waddr;
  logic [1:0]                         ch_wdata;
  logic                               tk_we;
  logic                               nt_we;
  logic [yags_pkg::SET_AW-1:0]        set_waddr;
  yags_pkg::yags_set_t                set_wdata;

  function automatic logic [1:0] sat2(logic [1:0] c, logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == yags_pkg::CTR_MAX) ? c : c + 2'd1;
    end else begin
      r = (c == 2'd0) ? c : c - 2'd1;
    end
    return r;
  endfunction

  function automatic yags_pkg::yags_set_t train(yags_pkg::yags_set_t s,
                                                logic [yags_pkg::TAG_W-1:0] t,
                                                logic out, logic taken_cache);
    yags_pkg::yags_set_t r;
    logic                victim;
    r = s;
    if (s.tag0 == t) begin
      r.ctr0 = sat2(s.ctr0, out);
    end else if (s.tag1 == t) begin
      r.ctr1 = sat2(s.ctr1, out);
    end else begin
      victim = ~s.lru;
      if (taken_cache && (s.ctr0[1] != s.ctr1[1])) begin
        victim = s.ctr0[1];
      end
      if (!victim) begin
        r.tag0 = t;
        r.ctr0 = {1'b0, out};
      end else begin
        r.tag1 = t;
        r.ctr1 = {1'b0, out};
      end
    end
    return r;
  endfunction

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && (state_q == S_IDLE);
  assign clearing = (state_q == S_CLEAR);

  assign acc_word = req_i.branch_address[31:2];
  assign acc_cai  = acc_word[yags_pkg::SET_AW-1:0] ^ hist_q[yags_pkg::HIST_W-1:1];

  assign word    = item_q.branch_address[31:2];
  assign outcome = item_q.taken_outcome;
  assign chi     = word[yags_pkg::CHOICE_AW-1:0];
  assign cai     = word[yags_pkg::SET_AW-1:0] ^ hist_q[yags_pkg::HIST_W-1:1];
  assign tag     = {word[yags_pkg::TAG_BITS-1:0], hist_q[0]};

  always_comb begin
    bias   = choice_rd[1];
    probed = bias ? nt_rd : tk_rd;
    way0   = (probed.tag0 == tag);
    hit    = way0 || (probed.tag1 == tag);
    cca    = way0 ? probed.ctr0 : probed.ctr1;
    pred   = hit ? cca[1] : bias;
    if (item_q.command == yags_pkg::CMD_UPDATE) begin
      choice_upd = !((bias != outcome) && hit && (outcome == pred));
      cache_wr   = bias ? (hit || !outcome) : (hit || outcome);
      set_wr     = train(probed, tag, outcome, !bias);
    end else begin
      choice_upd = 1'b0;
      cache_wr   = hit;
      set_wr     = probed;
      set_wr.lru = way0;
    end
  end

  assign clr_choice = ({1'b0, clr_q} < (yags_pkg::CLR_AW + 1)'(yags_pkg::CHOICE_ENTRIES));
  assign clr_set    = ({1'b0, clr_q} < (yags_pkg::CLR_AW + 1)'(yags_pkg::CACHE_SETS));

  always_comb begin
    if (clearing) begin
      ch_we     = clr_choice;
      ch_waddr  = clr_q[yags_pkg::CHOICE_AW-1:0];
      ch_wdata  = 2'd0;
      tk_we     = clr_set;
      nt_we     = clr_set;
      set_waddr = clr_q[yags_pkg::SET_AW-1:0];
      set_wdata = '0;
    end else begin
      ch_we     = (state_q == S_CALC) && choice_upd;
      ch_waddr  = chi;
      ch_wdata  = sat2(choice_rd, outcome);
      tk_we     = (state_q == S_CALC) && cache_wr && !bias;
      nt_we     = (state_q == S_CALC) && cache_wr && bias;
      set_waddr = cai;
      set_wdata = set_wr;
    end
  end

  yags_ram #(
    .WIDTH(2),
    .DEPTH(yags_pkg::CHOICE_ENTRIES)
  ) u_choice_ram (
    .clk_i  (clk_i),
    .we_i   (ch_we),
    .waddr_i(ch_waddr),
    .wdata_i(ch_wdata),
    .re_i   (accept),
    .raddr_i(acc_word[yags_pkg::CHOICE_AW-1:0]),
    .rdata_o(choice_rd)
  );

  yags_ram #(
    .WIDTH(yags_pkg::SET_W),
    .DEPTH(yags_pkg::CACHE_SETS)
  ) u_taken_ram (
    .clk_i  (clk_i),
    .we_i   (tk_we),
    .waddr_i(set_waddr),
    .wdata_i(set_wdata),
    .re_i   (accept),
    .raddr_i(acc_cai),
    .rdata_o(tk_rd)
  );

  yags_ram #(
    .WIDTH(yags_pkg::SET_W),
    .DEPTH(yags_pkg::CACHE_SETS)
  ) u_nottaken_ram (
    .clk_i  (clk_i),
    .we_i   (nt_we),
    .waddr_i(set_waddr),
    .wdata_i(set_wdata),
    .re_i   (accept),
    .raddr_i(acc_cai),
    .rdata_o(nt_rd)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hist_q      <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == yags_pkg::CLR_AW'(yags_pkg::CLR_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          rsp_valid_q         <= 1'b1;
          rsp_q.predict_taken <= pred;
          rsp_q.cache_hit     <= hit;
          if (item_q.command == yags_pkg::CMD_UPDATE) begin
            hist_q <= {hist_q[yags_pkg::HIST_W-2:0], outcome};
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CALC))
    else $error("accepted item did not enter calc");

  a_rsp_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q == S_CALC))
    else $error("result strobe without calc");

  a_hist_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hist_q) |-> $past(state_q == S_CALC && item_q.command == yags_pkg::CMD_UPDATE))
    else $error("history moved without update");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_we || tk_we || nt_we) |-> (state_q != S_IDLE))
    else $error("table write while idle");

  a_one_cache_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> !(tk_we && nt_we))
    else $error("both caches written for one item");

endmodule

// File: hdl/yags_ram.sv
`timescale 1ns / 1ps
module yags_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sim/yags_branch_predictor_checker.sv
`timescale 1ns / 1ps
module yags_branch_predictor_checker
  import yags_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  yags_req_t req_i,
  input  logic      rsp_valid_o,
  input  yags_rsp_t rsp_o,
  output int        fail_count,
  output int        pending_count
);

  logic [1:0]  choice_ctr    [CHOICE_ENTRIES];
  yags_set_t   taken_sets    [CACHE_SETS];
  yags_set_t   nottaken_sets [CACHE_SETS];
  logic [31:0] history;
  yags_rsp_t   expected_rsp_q [$];

  function automatic logic [1:0] step_ctr(logic [1:0] c, logic up);
    if (up) return (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    return (c == 2'd0) ? 2'd0 : c - 2'd1;
  endfunction

  function automatic yags_set_t train_set(yags_set_t s, logic [TAG_W-1:0] tag,
                                          logic outcome, logic taken_side);
    logic victim;
    if (s.tag0 == tag) begin
      s.ctr0 = step_ctr(s.ctr0, outcome);
      return s;
    end
    if (s.tag1 == tag) begin
      s.ctr1 = step_ctr(s.ctr1, outcome);
      return s;
    end
    victim = ~s.lru;
    // taken side prefers replacing the way that now predicts not taken
    if (taken_side && (s.ctr0[1] != s.ctr1[1])) victim = s.ctr0[1];
    if (!victim) begin
      s.tag0 = tag;
      s.ctr0 = {1'b0, outcome};
    end else begin
      s.tag1 = tag;
      s.ctr1 = {1'b0, outcome};
    end
    return s;
  endfunction

  task automatic predict_branch(input yags_req_t r, output yags_rsp_t rsp);
    logic [29:0]          word;
    logic [31:0]          hist_shift;
    logic [CHOICE_AW-1:0] chi;
    logic [SET_AW-1:0]    cai;
    logic [TAG_W-1:0]     tag;
    logic [1:0]           cch;
    logic [1:0]           way_ctr;
    logic                 bias;
    logic                 hit0;
    logic                 hit1;
    logic                 hit;
    logic                 pred;
    logic                 outcome;
    yags_set_t            probed;
    word       = r.branch_address[31:2];
    hist_shift = history >> 1;
    chi        = word[CHOICE_AW-1:0];
    cai        = word[SET_AW-1:0] ^ hist_shift[SET_AW-1:0];
    tag        = {word[TAG_BITS-1:0], history[0]};
    cch        = choice_ctr[chi];
    bias       = cch[1];
    probed     = bias ? nottaken_sets[cai] : taken_sets[cai];
    hit0       = (probed.tag0 == tag);
    hit1       = (probed.tag1 == tag);
    hit        = hit0 || hit1;
    way_ctr    = hit0 ? probed.ctr0 : probed.ctr1;
    pred       = hit ? way_ctr[1] : bias;
    outcome    = r.taken_outcome;
    if (r.command == CMD_LOOKUP) begin
      if (hit) begin
        probed.lru = hit0;
        if (bias) nottaken_sets[cai] = probed;
        else taken_sets[cai] = probed;
      end
    end else begin
      if (!((bias != outcome) && hit && (outcome == pred))) begin
        choice_ctr[chi] = step_ctr(cch, outcome);
      end
      if (bias && (hit || !outcome)) begin
        nottaken_sets[cai] = train_set(nottaken_sets[cai], tag, outcome, 1'b0);
      end
      if (!bias && (hit || outcome)) begin
        taken_sets[cai] = train_set(taken_sets[cai], tag, outcome, 1'b1);
      end
      history = {history[30:0], outcome};
    end
    rsp.predict_taken = pred;
    rsp.cache_hit     = hit;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    yags_rsp_t want;
    yags_rsp_t next_rsp;
    int        n_err;
    if (!rst_ni) begin
      for (int i = 0; i < CHOICE_ENTRIES; i++) choice_ctr[i] = 2'd0;
      for (int i = 0; i < CACHE_SETS; i++) begin
        taken_sets[i]    = '0;
        nottaken_sets[i] = '0;
      end
      history = '0;
      expected_rsp_q.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      n_err = 0;
      if (rsp_valid_o) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %b", $time, rsp_o);
          n_err++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_o.predict_taken !== want.predict_taken) begin
            $display("%0t: predict_taken mismatch, expected %b, actual %b", $time,
                     want.predict_taken, rsp_o.predict_taken);
            n_err++;
          end
          if (rsp_o.cache_hit !== want.cache_hit) begin
            $display("%0t: cache_hit mismatch, expected %b, actual %b", $time,
                     want.cache_hit, rsp_o.cache_hit);
            n_err++;
          end
        end
      end
      if (start && !busy) begin
        predict_branch(req_i, next_rsp);
        expected_rsp_q.push_back(next_rsp);
      end
      fail_count    <= fail_count + n_err;
      pending_count <= expected_rsp_q.size();
    end
  end

endmodule

// File: sim/yags_branch_predictor_core_test.sv
`timescale 1ns / 1ps
module yags_branch_predictor_core_test;
  import yags_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOT_COUNT    = 12;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  yags_req_t req_i  = '0;
  logic      busy;
  logic      rsp_valid_o;
  yags_rsp_t rsp_o;
  int        fail_count;
  int        pending_count;
  int        cycle_count;
  logic      burst_mode = 1'b0;

  logic [31:0] hot_addr    [HOT_COUNT];
  logic [7:0]  hot_pattern [HOT_COUNT];
  int          hot_phase   [HOT_COUNT];

  always #4 clk_i = ~clk_i;

  yags_branch_predictor_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  yags_branch_predictor_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .rsp_valid_o   (rsp_valid_o),
    .rsp_o         (rsp_o),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(yags_cmd_e cmd, logic [31:0] addr, logic outcome);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{command: cmd, branch_address: addr, taken_outcome: outcome};
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int     n_sent;
    int     k;
    int     r;
    logic   outcome;
    logic   paused;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset tags are zero, so address zero hits both ways at once
    send_item(CMD_LOOKUP, 32'h0000_0000, 1'b0);
    send_item(CMD_UPDATE, 32'h0000_0000, 1'b1);
    send_item(CMD_UPDATE, 32'h0000_0003, 1'b1);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_UPDATE, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_UPDATE, 32'hFFFF_FFFF, 1'b1);
    // saturate one choice counter toward taken, then train the not-taken side
    repeat (4) send_item(CMD_UPDATE, 32'h0000_1234, 1'b1);
    send_item(CMD_LOOKUP, 32'h0000_1234, 1'b0);
    repeat (3) send_item(CMD_UPDATE, 32'h0000_1234, 1'b0);
    send_item(CMD_LOOKUP, 32'h0000_1234, 1'b1);
    // back to not-taken bias, then allocate in the taken side
    repeat (3) send_item(CMD_UPDATE, 32'h8000_5678, 1'b0);
    repeat (3) send_item(CMD_UPDATE, 32'h8000_5678, 1'b1);
    send_item(CMD_LOOKUP, 32'h8000_5678, 1'b0);
    send_item(CMD_LOOKUP, 32'hAAAA_5555, 1'b1);

    for (int i = 0; i < HOT_COUNT; i++) begin
      if (i < 8) hot_addr[i] = $urandom;
      else hot_addr[i] = hot_addr[i - 8] ^ (32'h1 << $urandom_range(10, 31));
      case (i % 4)
        0: hot_pattern[i] = 8'hFF;
        1: hot_pattern[i] = 8'h00;
        2: hot_pattern[i] = 8'h55;
        default: hot_pattern[i] = 8'($urandom);
      endcase
      hot_phase[i] = 0;
    end

    n_sent = 0;
    paused = 1'b0;
    while (n_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
      if (!paused && n_sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        @(negedge clk_i);
        start <= 1'b0;
        while (pending_count != 0) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        k = $urandom_range(0, HOT_COUNT - 1);
        outcome = hot_pattern[k][hot_phase[k] % 8];
        hot_phase[k]++;
        send_item(CMD_LOOKUP, hot_addr[k], 1'($urandom_range(0, 1)));
        send_item(CMD_UPDATE, hot_addr[k], outcome);
        n_sent += 2;
      end else if (r < 85) begin
        send_item(CMD_UPDATE, $urandom, 1'($urandom_range(0, 1)));
        n_sent++;
      end else begin
        send_item(CMD_LOOKUP, $urandom, 1'($urandom_range(0, 1)));
        n_sent++;
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/yags_pkg.sv
hdl/yags_ram.sv
hdl/yags_branch_predictor_core.sv
sim/yags_branch_predictor_checker.sv
sim/yags_branch_predictor_core_test.sv
